// ----- hw/rtl/knn_pkg.sv -----
// Package for the k-nearest-neighbor classifier.
// Holds the action and register codes, the fixed field widths and the sequencer state type.
// No dependencies.
package knn_pkg;

    // Fixed field widths.
    localparam int FEATURE_BITS = 16;
    localparam int LABEL_W      = 4;
    localparam int NUM_CLASSES  = 16;
    localparam int CFG_W        = 5;
    localparam int CFG_IDX_W    = 1;

    // Action codes of an input item.
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_TRAIN = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_K_NEIGHBOURS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT = 1'd1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST,
        ST_WAIT,
        ST_INSERT,
        ST_VOTE
    } t_state;

endpackage

// ----- hw/rtl/knn_classifier.sv -----
// k-nearest-neighbor classifier top level: training store, query store, distance datapath,
// sorted neighbor lanes and voting sequencer.
// Depends on knn_pkg.
//
// Usage: items enter on i_valid / o_stall with fields i_action, i_feature_value and
// i_class_label. A clear item empties the training store; training items fill a row
// element by element, the label taken with the row's last element. Query items load the
// query row; the last one starts a classification and the block raises o_stall until the
// result item is delivered on o_valid / i_stall.
// A query with fewer stored rows than k answers in the next cycle with too_few_rows set.
// Otherwise the walk visits the stored rows in turn: each row streams its F features
// through one shared subtract-square-accumulate unit fed by the single read port
// of the training memory, waits for the pipeline to drain, then inserts its distance
// into the sorted neighbor lanes; the vote then steps through the k nearest labels.
// While the receiver stalls, the result holds and no new item is taken.
// Reset (synchronous, active low) empties the store and sets k to 3 and the feature
// count to 4; stored features and labels are not cleared and need no clearing pass.
module knn_classifier #(
    parameter int MAX_ROWS     = 1024,
    parameter int MAX_FEATURES = 16,
    parameter int MAX_K        = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [1:0]                           i_action,
    input  logic signed [knn_pkg::FEATURE_BITS-1:0] i_feature_value,
    input  logic [knn_pkg::LABEL_W-1:0]          i_class_label,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [knn_pkg::LABEL_W-1:0]          o_predicted_class,
    output logic                                 o_too_few_rows,
    input  logic                                 i_cfg_we,
    input  logic [knn_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [knn_pkg::CFG_W-1:0]            i_cfg_data
);
    import knn_pkg::*;

    localparam int F_W    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int RI_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RC_W   = $clog2(MAX_ROWS + 1);
    localparam int FC_W   = $clog2(MAX_FEATURES + 1);
    localparam int KC_W   = $clog2(MAX_K + 1);
    localparam int KI_W   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int SQ_W   = 2 * FEATURE_BITS + 2;
    localparam int DIST_W = SQ_W + $clog2(MAX_FEATURES);
    localparam int FMEM_D = MAX_ROWS * (2 ** F_W);
    localparam int QMEM_D = 2 ** F_W;

    // Configuration and control state.
    logic [CFG_W-1:0] r_k_cfg, r_fc_cfg;
    logic [RC_W-1:0]  r_row_count;
    logic [F_W-1:0]   r_elem;
    t_state           r_state, n_state;

    // Walk state.
    logic [RC_W-1:0]  r_row;
    logic [F_W-1:0]   r_f;
    logic             r_p1_v, r_p1_last, r_p2_v, r_p2_last;
    logic [SQ_W-1:0]  r_sq;
    logic [DIST_W-1:0] r_acc;
    logic [KI_W-1:0]  r_vi;

    // Memories and their read registers.
    logic [FEATURE_BITS-1:0] r_fmem [FMEM_D];
    logic [FEATURE_BITS-1:0] r_qmem [QMEM_D];
    logic [LABEL_W-1:0]      r_lmem [MAX_ROWS];
    logic [FEATURE_BITS-1:0] r_t_rd, r_q_rd;
    logic [LABEL_W-1:0]      r_l_rd;

    // Neighbor lanes and vote counters.
    logic [DIST_W-1:0]  r_bd [MAX_K];
    logic [LABEL_W-1:0] r_bl [MAX_K];
    logic [KC_W-1:0]    r_votes [NUM_CLASSES];
    logic [KC_W-1:0]    r_best_votes;
    logic [LABEL_W-1:0] r_winner;

    // Result register.
    logic               r_out_valid;
    logic [LABEL_W-1:0] r_out_class;
    logic               r_out_few;

    // Effective register values.
    logic [FC_W-1:0] nf;
    logic [KC_W-1:0] k_eff;

    always_comb begin
        if (r_fc_cfg == '0) begin
            nf = FC_W'(1);
        end else if (32'(r_fc_cfg) > 32'(MAX_FEATURES)) begin
            nf = FC_W'(MAX_FEATURES);
        end else begin
            nf = FC_W'(r_fc_cfg);
        end
        if (r_k_cfg == '0) begin
            k_eff = KC_W'(1);
        end else if (32'(r_k_cfg) > 32'(MAX_K)) begin
            k_eff = KC_W'(MAX_K);
        end else begin
            k_eff = KC_W'(r_k_cfg);
        end
    end

    // Item decode.
    logic in_acc, elem_last, store_ok, query_last, too_few, go, issue_last, vote_last;
    logic row_done, out_acc;

    assign in_acc     = i_valid && !o_stall;
    assign elem_last  = (32'(r_elem) + 32'd1) >= 32'(nf);
    assign store_ok   = 32'(r_row_count) < 32'(MAX_ROWS);
    assign query_last = in_acc && (i_action == ACT_QUERY) && elem_last;
    assign too_few    = 32'(k_eff) > 32'(r_row_count);
    assign go         = query_last && !too_few;
    assign issue_last = (32'(r_f) + 32'd1) >= 32'(nf);
    assign row_done   = (32'(r_row) + 32'd1) == 32'(r_row_count);
    assign vote_last  = (32'(r_vi) + 32'd1) == 32'(k_eff);
    assign out_acc    = o_valid && !i_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (go) n_state = ST_DIST;
            ST_DIST:   if (issue_last) n_state = ST_WAIT;
            ST_WAIT:   if (r_p2_v && r_p2_last) n_state = ST_INSERT;
            ST_INSERT: n_state = row_done ? ST_VOTE : ST_DIST;
            ST_VOTE:   if (vote_last) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    logic issue, insert, voting;

    always_comb begin
        o_stall = 1'b1;
        issue   = 1'b0;
        insert  = 1'b0;
        voting  = 1'b0;
        case (r_state)
            ST_IDLE:   o_stall = r_out_valid;
            ST_DIST:   issue   = 1'b1;
            ST_WAIT:   issue   = 1'b0;
            ST_INSERT: insert  = 1'b1;
            ST_VOTE:   voting  = 1'b1;
            default:   o_stall = 1'b1;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k_cfg     <= CFG_W'(3);
            r_fc_cfg    <= CFG_W'(4);
            r_row_count <= '0;
            r_elem      <= '0;
            r_out_valid <= 1'b0;
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_K_NEIGHBOURS:  r_k_cfg  <= i_cfg_data;
                    CFG_FEATURE_COUNT: r_fc_cfg <= i_cfg_data;
                    default:           r_k_cfg  <= r_k_cfg;
                endcase
            end
            if (in_acc) begin
                if (i_action == ACT_CLEAR) begin
                    r_row_count <= '0;
                    r_elem      <= '0;
                end else if (i_action == ACT_TRAIN || i_action == ACT_QUERY) begin
                    r_elem <= elem_last ? '0 : r_elem + F_W'(1);
                    if (i_action == ACT_TRAIN && store_ok && elem_last) begin
                        r_row_count <= r_row_count + RC_W'(1);
                    end
                end
            end
            r_p1_v <= issue;
            r_p2_v <= r_p1_v;
            if (query_last && too_few) begin
                r_out_valid <= 1'b1;
            end else if (voting && vote_last) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Memories: one write port, registered read.
    always_ff @(posedge i_clk) begin
        if (in_acc && i_action == ACT_TRAIN && store_ok) begin
            r_fmem[{r_row_count[RI_W-1:0], r_elem}] <= i_feature_value;
            if (elem_last) begin
                r_lmem[r_row_count[RI_W-1:0]] <= i_class_label;
            end
        end
        if (in_acc && i_action == ACT_QUERY) begin
            r_qmem[r_elem] <= i_feature_value;
        end
        r_t_rd <= r_fmem[{r_row[RI_W-1:0], r_f}];
        r_q_rd <= r_qmem[r_f];
        r_l_rd <= r_lmem[r_row[RI_W-1:0]];
    end

    // Shared subtract, square and accumulate unit.
    logic signed [FEATURE_BITS:0]   diff;
    logic signed [2*FEATURE_BITS+1:0] sq_full;

    assign diff    = $signed({r_q_rd[FEATURE_BITS-1], r_q_rd})
                   - $signed({r_t_rd[FEATURE_BITS-1], r_t_rd});
    assign sq_full = diff * diff;

    always_ff @(posedge i_clk) begin
        r_p1_last <= issue_last;
        r_p2_last <= r_p1_last;
        r_sq      <= SQ_W'($unsigned(sq_full));
        if (go) begin
            r_row <= '0;
            r_f   <= '0;
            r_acc <= '0;
        end else if (insert) begin
            r_row <= r_row + RC_W'(1);
            r_f   <= '0;
            r_acc <= '0;
        end else begin
            if (issue) begin
                r_f <= r_f + F_W'(1);
            end
            if (r_p2_v) begin
                r_acc <= r_acc + DIST_W'(r_sq);
            end
        end
    end

    // Neighbor lanes: sorted insertion, ties after equal entries; shifted out while voting.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_K; i++) begin
            if (go) begin
                r_bd[i] <= '1;
                r_bl[i] <= '0;
            end else if (insert && (32'(i) < 32'(k_eff)) && (r_acc < r_bd[i])) begin
                if (i > 0 && r_acc < r_bd[(i > 0) ? i - 1 : 0]) begin
                    r_bd[i] <= r_bd[(i > 0) ? i - 1 : 0];
                    r_bl[i] <= r_bl[(i > 0) ? i - 1 : 0];
                end else begin
                    r_bd[i] <= r_acc;
                    r_bl[i] <= r_l_rd;
                end
            end else if (voting) begin
                r_bl[i] <= (i < MAX_K - 1) ? r_bl[(i < MAX_K - 1) ? i + 1 : i] : '0;
            end
        end
    end

    // Voting: on a tie, the label that reached the top count first wins.
    logic [KC_W-1:0] cnt_next;

    assign cnt_next = r_votes[r_bl[0]] + KC_W'(1);

    always_ff @(posedge i_clk) begin
        if (go) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_votes[c] <= '0;
            end
            r_best_votes <= '0;
            r_winner     <= '0;
            r_vi         <= '0;
        end else if (voting) begin
            r_votes[r_bl[0]] <= cnt_next;
            r_vi             <= r_vi + KI_W'(1);
            if (cnt_next > r_best_votes) begin
                r_best_votes <= cnt_next;
                r_winner     <= r_bl[0];
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (query_last && too_few) begin
            r_out_class <= '0;
            r_out_few   <= 1'b1;
        end else if (voting && vote_last) begin
            r_out_class <= (cnt_next > r_best_votes) ? r_bl[0] : r_winner;
            r_out_few   <= 1'b0;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_predicted_class = r_out_class;
    assign o_too_few_rows    = r_out_few;

endmodule
